// ===== sv/scbs_pkg.sv =====
// ----------------------------------------------------------------------------
// scbs_pkg
// Shared types and constants of the sample-consensus background subtractor.
// ----------------------------------------------------------------------------
package scbs_pkg;

   localparam int CNT_W  = 7;
   localparam int DIST_W = 18;

   localparam logic [2:0] CSR_DIST_THRESHOLD   = 3'd0;
   localparam logic [2:0] CSR_SAMPLE_COUNT     = 3'd1;
   localparam logic [2:0] CSR_REQUIRED_MATCHES = 3'd2;
   localparam logic [2:0] CSR_LEARNING_MASK    = 3'd3;
   localparam logic [2:0] CSR_COLOR_MODE       = 3'd4;
   localparam logic [2:0] CSR_IMAGE_WIDTH      = 3'd5;
   localparam logic [2:0] CSR_IMAGE_HEIGHT     = 3'd6;

   localparam logic FUNC_LOAD     = 1'b0;
   localparam logic FUNC_CLASSIFY = 1'b1;

   typedef struct packed {
      logic cap;
      logic mem_rd;
      logic dist_en;
      logic cmp_en;
      logic wr_load;
      logic wr_self;
      logic wr_nei;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_load;
      logic in_frame;
      logic walk_empty;
      logic last;
      logic hit_stop;
      logic rsp_free;
   } ctrl_sts_type;

   // neighbour offsets, raster order without the centre
   function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
      logic signed [1:0] v;
      case (d)
         3'd0, 3'd3, 3'd5: v = -2'sd1;
         3'd1, 3'd6:       v = 2'sd0;
         default:          v = 2'sd1;
      endcase
      return v;
   endfunction

   function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
      logic signed [1:0] v;
      case (d)
         3'd0, 3'd1, 3'd2: v = -2'sd1;
         3'd3, 3'd4:       v = 2'sd0;
         default:          v = 2'sd1;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/scbs_ram.sv =====
// ----------------------------------------------------------------------------
// scbs_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module scbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/scbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// scbs_ctrl
// Sequencer: load write, sample walk, updates and result hand-off.
// ----------------------------------------------------------------------------
module scbs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  scbs_pkg::ctrl_sts_type sts,
   output scbs_pkg::ctrl_cmd_type cmd
);
   import scbs_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_CHK  = 9'b000000010,
      ST_LOAD = 9'b000000100,
      ST_RD   = 9'b000001000,
      ST_DIST = 9'b000010000,
      ST_CMP  = 9'b000100000,
      ST_UPS  = 9'b001000000,
      ST_UPN  = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.cap  = 1'b1;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (!sts.in_frame) begin
               state_in = ST_DONE;
            end else if (sts.is_load) begin
               state_in = ST_LOAD;
            end else if (sts.walk_empty) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_LOAD: begin
            cmd.wr_load = 1'b1;
            state_in    = ST_DONE;
         end
         ST_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_DIST;
         end
         ST_DIST: begin
            cmd.dist_en = 1'b1;
            state_in    = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp_en = 1'b1;
            if (sts.hit_stop) begin
               state_in = ST_UPS;
            end else if (sts.last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_UPS: begin
            cmd.wr_self = 1'b1;
            state_in    = ST_UPN;
         end
         ST_UPN: begin
            cmd.wr_nei = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_rd_then_dist: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_rd |=> cmd.dist_en)
      else $error("read not followed by distance stage");

   a_self_then_nei: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_self |=> cmd.wr_nei)
      else $error("own update not followed by neighbour update");

   a_no_rd_wr: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_rd && (cmd.wr_load || cmd.wr_self || cmd.wr_nei)))
      else $error("read and write in the same cycle");

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("result loaded over a waiting word");
endmodule

// ===== sv/scbs_dp.sv =====
// ----------------------------------------------------------------------------
// scbs_dp
// Datapath: registers, item latch, sample memory, distance and update logic.
// ----------------------------------------------------------------------------
module scbs_dp #(
   parameter int MAX_SAMPLES = 32,
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [2:0]             csr_index,
   input  logic [8:0]             csr_data,
   input  logic                   req_func,
   input  logic [7:0]             req_col,
   input  logic [7:0]             req_row,
   input  logic [7:0]             req_chan0,
   input  logic [7:0]             req_chan1,
   input  logic [7:0]             req_chan2,
   input  logic [4:0]             req_load_slot,
   input  logic [31:0]            req_self_gate,
   input  logic [4:0]             req_self_slot,
   input  logic [31:0]            req_neigh_gate,
   input  logic [2:0]             req_neigh_dir,
   input  logic [4:0]             req_neigh_slot,
   input  scbs_pkg::ctrl_cmd_type cmd,
   output scbs_pkg::ctrl_sts_type sts,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_is_foreground,
   output logic [5:0]             rsp_match_count
);
   import scbs_pkg::*;

   localparam int SW    = $clog2(MAX_SAMPLES);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int AW    = SW + RW + CW;
   localparam int DEPTH = 2 ** AW;

   logic [8:0] thr_ff;
   logic [5:0] scount_ff;
   logic [5:0] req_m_ff;
   logic [4:0] mask_ff;
   logic       color_ff;
   logic [8:0] imw_ff;
   logic [8:0] imh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= 9'd20;
         scount_ff <= 6'd20;
         req_m_ff  <= 6'd2;
         mask_ff   <= 5'd15;
         color_ff  <= 1'b1;
         imw_ff    <= 9'd256;
         imh_ff    <= 9'd256;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DIST_THRESHOLD:   thr_ff    <= csr_data;
            CSR_SAMPLE_COUNT:     scount_ff <= csr_data[5:0];
            CSR_REQUIRED_MATCHES: req_m_ff  <= csr_data[5:0];
            CSR_LEARNING_MASK:    mask_ff   <= csr_data[4:0];
            CSR_COLOR_MODE:       color_ff  <= csr_data[0];
            CSR_IMAGE_WIDTH:      imw_ff    <= csr_data;
            CSR_IMAGE_HEIGHT:     imh_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   logic [CNT_W-1:0] n_eff;
   logic [8:0]       w_eff, h_eff, w_m1, h_m1;

   assign n_eff = (CNT_W'(scount_ff) < CNT_W'(MAX_SAMPLES)) ? CNT_W'(scount_ff)
                                                            : CNT_W'(MAX_SAMPLES);
   assign w_eff = (13'(imw_ff) < 13'(MAX_WIDTH)) ? imw_ff : 9'(MAX_WIDTH);
   assign h_eff = (13'(imh_ff) < 13'(MAX_HEIGHT)) ? imh_ff : 9'(MAX_HEIGHT);
   assign w_m1  = w_eff - 9'd1;
   assign h_m1  = h_eff - 9'd1;

   // item latch
   logic        func_ff;
   logic [7:0]  col_ff, row_ff;
   logic [23:0] pix_ff;
   logic [4:0]  lslot_ff, sslot_ff, nslot_ff;
   logic        sgo_ff, ngo_ff;
   logic [2:0]  dir_ff;
   logic [DIST_W-1:0] thr_cmp_ff;

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         func_ff    <= req_func;
         col_ff     <= req_col;
         row_ff     <= req_row;
         pix_ff     <= {req_chan2, req_chan1, req_chan0};
         lslot_ff   <= req_load_slot;
         sslot_ff   <= req_self_slot & mask_ff;
         nslot_ff   <= req_neigh_slot & mask_ff;
         sgo_ff     <= (req_self_gate[4:0] & mask_ff) == 5'd0;
         ngo_ff     <= (req_neigh_gate[4:0] & mask_ff) == 5'd0;
         dir_ff     <= req_neigh_dir;
         thr_cmp_ff <= color_ff ? DIST_W'(thr_ff) * DIST_W'(thr_ff) : DIST_W'(thr_ff);
      end
   end

   // walk
   logic [CNT_W-1:0]  s_ff, cnt_ff;
   logic [DIST_W-1:0] dist_ff;
   logic              match;
   logic [23:0]       rdata;

   assign match = dist_ff < thr_cmp_ff;

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         s_ff   <= '0;
         cnt_ff <= '0;
      end else if (cmd.cmp_en) begin
         s_ff <= s_ff + CNT_W'(1);
         if (match) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   logic [7:0]  d0, d1, d2;
   logic [15:0] q0, q1, q2;

   always_comb begin
      d0 = (pix_ff[7:0] > rdata[7:0]) ? pix_ff[7:0] - rdata[7:0] : rdata[7:0] - pix_ff[7:0];
      d1 = (pix_ff[15:8] > rdata[15:8]) ? pix_ff[15:8] - rdata[15:8]
                                        : rdata[15:8] - pix_ff[15:8];
      d2 = (pix_ff[23:16] > rdata[23:16]) ? pix_ff[23:16] - rdata[23:16]
                                          : rdata[23:16] - pix_ff[23:16];
      q0 = 16'(d0) * 16'(d0);
      q1 = 16'(d1) * 16'(d1);
      q2 = 16'(d2) * 16'(d2);
   end

   always_ff @(posedge clock) begin
      if (cmd.dist_en) begin
         dist_ff <= color_ff ? DIST_W'(q0) + DIST_W'(q1) + DIST_W'(q2) : DIST_W'(d0);
      end
   end

   // neighbour position, clamped into the frame
   logic signed [9:0] nx_s, ny_s;
   logic [7:0]        nx, ny;

   always_comb begin
      nx_s = $signed({2'b00, col_ff}) + 10'(dir_dx(dir_ff));
      ny_s = $signed({2'b00, row_ff}) + 10'(dir_dy(dir_ff));
      if (nx_s < 10'sd0) begin
         nx = 8'd0;
      end else if (nx_s > $signed({1'b0, w_m1})) begin
         nx = w_m1[7:0];
      end else begin
         nx = nx_s[7:0];
      end
      if (ny_s < 10'sd0) begin
         ny = 8'd0;
      end else if (ny_s > $signed({1'b0, h_m1})) begin
         ny = h_m1[7:0];
      end else begin
         ny = ny_s[7:0];
      end
   end

   // memory port
   logic [CNT_W-1:0] slot_sel;
   logic [7:0]       col_sel, row_sel;
   logic             lo_we, hi_we;
   logic [SW+CNT_W-1:0] slot_x;
   logic [RW+7:0]    row_x;
   logic [CW+7:0]    col_x;
   logic [AW-1:0]    addr;

   always_comb begin
      slot_sel = s_ff;
      col_sel  = col_ff;
      row_sel  = row_ff;
      lo_we    = 1'b0;
      hi_we    = 1'b0;
      if (cmd.wr_load) begin
         slot_sel = CNT_W'(lslot_ff);
         lo_we    = CNT_W'(lslot_ff) < n_eff;
         hi_we    = lo_we;
      end else if (cmd.wr_self) begin
         slot_sel = CNT_W'(sslot_ff);
         lo_we    = sgo_ff && (CNT_W'(sslot_ff) < n_eff);
         hi_we    = lo_we && color_ff;
      end else if (cmd.wr_nei) begin
         slot_sel = CNT_W'(nslot_ff);
         col_sel  = nx;
         row_sel  = ny;
         lo_we    = ngo_ff && (CNT_W'(nslot_ff) < n_eff);
         hi_we    = lo_we && color_ff;
      end
      slot_x = (SW + CNT_W)'(slot_sel);
      row_x  = (RW + 8)'(row_sel);
      col_x  = (CW + 8)'(col_sel);
      addr   = {slot_x[SW-1:0], row_x[RW-1:0], col_x[CW-1:0]};
   end

   scbs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_lo (
      .clock (clock),
      .we    (lo_we),
      .addr  (addr),
      .wdata (pix_ff[7:0]),
      .rdata (rdata[7:0])
   );

   scbs_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram_hi (
      .clock (clock),
      .we    (hi_we),
      .addr  (addr),
      .wdata (pix_ff[23:8]),
      .rdata (rdata[23:8])
   );

   // result word
   logic       rsp_valid_ff;
   logic       fg_ff;
   logic [5:0] mc_ff;
   logic       in_frame;

   assign in_frame = ({1'b0, col_ff} < w_eff) && ({1'b0, row_ff} < h_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         fg_ff <= (func_ff == FUNC_CLASSIFY) && in_frame && (cnt_ff < CNT_W'(req_m_ff));
         mc_ff <= cnt_ff[5:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_foreground = fg_ff;
   assign rsp_match_count   = mc_ff;

   assign sts.is_load    = func_ff == FUNC_LOAD;
   assign sts.in_frame   = in_frame;
   assign sts.walk_empty = n_eff == '0;
   assign sts.last       = (s_ff + CNT_W'(1)) >= n_eff;
   assign sts.hit_stop   = match && ((cnt_ff + CNT_W'(1)) >= CNT_W'(req_m_ff));
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;
endmodule

// ===== sv/sample_consensus_background_subtractor.sv =====
// ----------------------------------------------------------------------------
// sample_consensus_background_subtractor
// Per-pixel sample-consensus background model with stored-sample updates.
// ----------------------------------------------------------------------------
// One word at a time. A load captures the word, checks it, writes the sample
// and loads the result. A classify examines each sample in turn (memory read,
// registered distance, compare) and stops early once enough samples match;
// when the pixel turns out background the own and then the neighbour updates
// are written. The next word is accepted once the previous result is loaded
// into the output register. The sample store is not cleared after reset; a
// sample must be loaded before it is classified.
module sample_consensus_background_subtractor #(
   parameter int MAX_SAMPLES = 32,
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_col,
   input  logic [7:0]  req_row,
   input  logic [7:0]  req_chan0,
   input  logic [7:0]  req_chan1,
   input  logic [7:0]  req_chan2,
   input  logic [4:0]  req_load_slot,
   input  logic [31:0] req_self_gate,
   input  logic [4:0]  req_self_slot,
   input  logic [31:0] req_neigh_gate,
   input  logic [2:0]  req_neigh_dir,
   input  logic [4:0]  req_neigh_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_foreground,
   output logic [5:0]  rsp_match_count
);
   import scbs_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   assign csr_ready = 1'b1;

   scbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   scbs_dp #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_func          (req_func),
      .req_col           (req_col),
      .req_row           (req_row),
      .req_chan0         (req_chan0),
      .req_chan1         (req_chan1),
      .req_chan2         (req_chan2),
      .req_load_slot     (req_load_slot),
      .req_self_gate     (req_self_gate),
      .req_self_slot     (req_self_slot),
      .req_neigh_gate    (req_neigh_gate),
      .req_neigh_dir     (req_neigh_dir),
      .req_neigh_slot    (req_neigh_slot),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_is_foreground (rsp_is_foreground),
      .rsp_match_count   (rsp_match_count)
   );
endmodule
